FILE: rtl/tcbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbe_pkg
// Shared types and constants of the chained TEA block encryptor.
// ----------------------------------------------------------------------------
package tcbe_pkg;

    localparam int BLOCK_W   = 64;
    localparam int WORD_W    = 32;
    localparam int KEY_IDX_W = 2;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = 1;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E3779B9;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [WORD_W-1:0]  t_word;

    typedef struct packed {
        t_block plain;
        logic   first;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        t_word k0;
        t_word k1;
        t_word k2;
        t_word k3;
    } t_key;

    typedef enum logic [KEY_IDX_W-1:0] {
        KEY_W0,
        KEY_W1,
        KEY_W2,
        KEY_W3
    } t_key_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    function automatic t_block tea_round(input t_block v, input t_word sum, input t_key k);
        t_word v0;
        t_word v1;
        v0 = v[BLOCK_W-1:WORD_W];
        v1 = v[WORD_W-1:0];
        v0 = v0 + (((v1 << 4) + k.k0) ^ (v1 + sum) ^ ((v1 >> 5) + k.k1));
        v1 = v1 + (((v0 << 4) + k.k2) ^ (v0 + sum) ^ ((v0 >> 5) + k.k3));
        return {v0, v1};
    endfunction

endpackage

FILE: rtl/tcbe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbe_queue
// Front end: accepts plaintext blocks with their first-block flag and holds
// them in a short queue for the cipher engine.
// ----------------------------------------------------------------------------
module tcbe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tcbe_pkg::t_item  i_item,
    output tcbe_pkg::t_q_head o_head,
    input  logic             i_pop
);

    tcbe_pkg::t_item              r_mem [tcbe_pkg::QDEPTH];
    logic [tcbe_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [tcbe_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [tcbe_pkg::QPTR_W:0]    r_count;
    logic                         push;
    logic                         pop;

    assign o_ready = (r_count != (tcbe_pkg::QPTR_W + 1)'(tcbe_pkg::QDEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/tcbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbe_back
// Back end: chains each block, runs the TEA rounds one per cycle and
// registers the ciphertext for the output stream.
// ----------------------------------------------------------------------------
module tcbe_back #(
    parameter int ROUNDS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcbe_pkg::t_q_head i_head,
    output logic              o_pop,
    input  tcbe_pkg::t_key    i_key,
    output logic              o_valid,
    input  logic              i_ready,
    output tcbe_pkg::t_block  o_data
);

    localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROUNDS - 1);

    tcbe_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    tcbe_pkg::t_block r_v, n_v;
    tcbe_pkg::t_word  r_sum, n_sum;
    tcbe_pkg::t_block r_mixed, n_mixed;
    tcbe_pkg::t_block r_chain_mixed, n_chain_mixed;
    tcbe_pkg::t_block r_prev_cipher, n_prev_cipher;
    tcbe_pkg::t_block r_prev_mixed, n_prev_mixed;
    logic             r_out_valid, n_out_valid;
    tcbe_pkg::t_block r_out_data, n_out_data;

    tcbe_pkg::t_word  sum_step;
    tcbe_pkg::t_block round_v;
    tcbe_pkg::t_block fin_cipher;
    tcbe_pkg::t_block load_mixed;
    tcbe_pkg::t_block load_chain;
    logic             out_free;
    logic             load;

    assign sum_step   = r_sum + tcbe_pkg::TEA_DELTA;
    assign round_v    = tcbe_pkg::tea_round(r_v, sum_step, i_key);
    assign fin_cipher = r_v ^ r_chain_mixed;
    assign out_free   = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tcbe_pkg::ST_IDLE;
            r_cnt         <= '0;
            r_prev_cipher <= '0;
            r_prev_mixed  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_prev_cipher <= n_prev_cipher;
            r_prev_mixed  <= n_prev_mixed;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v           <= n_v;
        r_sum         <= n_sum;
        r_mixed       <= n_mixed;
        r_chain_mixed <= n_chain_mixed;
        r_out_data    <= n_out_data;
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_v           = r_v;
        n_sum         = r_sum;
        n_mixed       = r_mixed;
        n_chain_mixed = r_chain_mixed;
        n_prev_cipher = r_prev_cipher;
        n_prev_mixed  = r_prev_mixed;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_data    = r_out_data;
        load          = 1'b0;
        o_pop         = 1'b0;
        load_mixed    = '0;
        load_chain    = '0;

        case (r_state)
            tcbe_pkg::ST_IDLE: begin
                load = i_head.valid;
            end
            tcbe_pkg::ST_RUN: begin
                n_v   = round_v;
                n_sum = sum_step;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = tcbe_pkg::ST_FIN;
                end
            end
            tcbe_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_data    = fin_cipher;
                    n_prev_cipher = fin_cipher;
                    n_prev_mixed  = r_mixed;
                    n_state       = tcbe_pkg::ST_IDLE;
                    load          = i_head.valid;
                end
            end
            default: begin
                n_state = tcbe_pkg::ST_IDLE;
            end
        endcase

        // chain against the values just settled, so a block can follow at once
        load_mixed = i_head.item.plain ^ (i_head.item.first ? '0 : n_prev_cipher);
        load_chain = i_head.item.first ? '0 : n_prev_mixed;

        if (load) begin
            o_pop         = 1'b1;
            n_v           = load_mixed;
            n_mixed       = load_mixed;
            n_chain_mixed = load_chain;
            n_sum         = '0;
            n_cnt         = '0;
            n_state       = tcbe_pkg::ST_RUN;
        end
    end

endmodule

FILE: rtl/tea_chained_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_chained_block_encrypt
// TEA block encryptor in the QQ chained mode.
// ----------------------------------------------------------------------------
// Each 64-bit padded plaintext block is xored with the previous ciphertext,
// enciphered with ROUNDS rounds of TEA under the 128-bit key, and xored with
// the previous mixed block; tuser high marks the first block of a message and
// zeroes both chaining values. One shared round unit does one round per
// cycle, and each block waits for the ciphertext of the one before it, so
// the engine takes no new block until the last has gone to the output
// register. A two-entry input queue and an output register let either side
// stall on its own. Key registers must be written by the user only while no
// block is in flight and act on the next block; the core does not enforce it.
// ----------------------------------------------------------------------------
module tea_chained_block_encrypt #(
    parameter int ROUNDS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tcbe_pkg::KEY_IDX_W-1:0]     i_cfg_idx,
    input  logic [tcbe_pkg::WORD_W-1:0]        i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tcbe_pkg::BLOCK_W-1:0]       s_axis_tdata,   // plain_block
    input  logic                               s_axis_tuser,   // first_block
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tcbe_pkg::BLOCK_W-1:0]       m_axis_tdata    // cipher_block
);

    tcbe_pkg::t_key    r_key;
    tcbe_pkg::t_item   in_item;
    tcbe_pkg::t_q_head q_head;
    logic              q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (tcbe_pkg::t_key_idx'(i_cfg_idx))
                tcbe_pkg::KEY_W0: r_key.k0 <= i_cfg_data;
                tcbe_pkg::KEY_W1: r_key.k1 <= i_cfg_data;
                tcbe_pkg::KEY_W2: r_key.k2 <= i_cfg_data;
                tcbe_pkg::KEY_W3: r_key.k3 <= i_cfg_data;
                default:          r_key    <= r_key;
            endcase
        end
    end

    assign in_item.plain = s_axis_tdata;
    assign in_item.first = s_axis_tuser;

    tcbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    tcbe_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .i_key   (r_key),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

FILE: rtl/tcbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbe_checker
// Port-level checks of the chained TEA block encryptor, bound to the top.
// ----------------------------------------------------------------------------
module tcbe_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [tcbe_pkg::BLOCK_W-1:0] m_axis_tdata
);

    localparam logic [2:0] CAP = 3'(tcbe_pkg::QDEPTH + 2);

    logic [2:0] r_pending;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // count blocks accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({in_xfer, out_xfer})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 3'd0)
        else $error("output offered with no block outstanding");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == CAP |-> !s_axis_tready)
        else $error("input ready with every slot occupied");

endmodule

bind tea_chained_block_encrypt tcbe_checker u_tcbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the chained TEA block encryptor.
// ----------------------------------------------------------------------------
// A queue of plaintext blocks feeds a clocked stream driver. Every accepted
// transfer is run through a local 16-round TEA model with the QQ chaining.
// The ciphertext it predicts is queued and compared with each output
// transfer. Directed blocks come first: the first-block mark, all-zero and
// all-one blocks, blocks sent before any first block, and a key change in the
// middle of a message. Random messages follow under several keys.
// ----------------------------------------------------------------------------
module tb;

    localparam int              ROUNDS      = 16;
    localparam tcbe_pkg::t_word ROUND_DELTA = 32'h9E3779B9;
    localparam int              LIMIT       = 400_000;
    localparam int              HOLD_AT     = 80;
    localparam int              HOLD_CYCLES = 600;
    localparam int              N_PHASES    = 8;
    localparam int              PHASE_ITEMS = 170;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_cfg_we = 1'b0;
    logic [tcbe_pkg::KEY_IDX_W-1:0] i_cfg_idx = '0;
    tcbe_pkg::t_word  i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    tcbe_pkg::t_block s_axis_tdata = '0;      // plain_block
    logic             s_axis_tuser = 1'b0;    // first_block
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    tcbe_pkg::t_block m_axis_tdata;           // cipher_block

    tcbe_pkg::t_item  plain_pending[$];
    tcbe_pkg::t_block cipher_expect[$];

    tcbe_pkg::t_key   key_model = '0;
    tcbe_pkg::t_block chain_cipher = '0;
    tcbe_pkg::t_block chain_mixed = '0;
    tcbe_pkg::t_block mixed_v;
    tcbe_pkg::t_block cipher_v;
    tcbe_pkg::t_block want_v;
    logic             tx_taken;

    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     in_count = 0;
    int     out_count = 0;
    int     first_count = 0;
    int     key_loads = 0;
    int     errors = 0;
    int     cycles = 0;
    int     hold_left = 0;
    logic   hold_done = 1'b0;

    tea_chained_block_encrypt #(
        .ROUNDS(ROUNDS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic tcbe_pkg::t_block tea_encipher(input tcbe_pkg::t_block blk,
                                                      input tcbe_pkg::t_key key);
        tcbe_pkg::t_word y;
        tcbe_pkg::t_word z;
        tcbe_pkg::t_word acc;
        int              r;
        y   = blk[63:32];
        z   = blk[31:0];
        acc = '0;
        for (r = 0; r < ROUNDS; r++) begin
            acc = acc + ROUND_DELTA;
            y = y + (((z << 4) + key.k0) ^ (z + acc) ^ ((z >> 5) + key.k1));
            z = z + (((y << 4) + key.k2) ^ (y + acc) ^ ((y >> 5) + key.k3));
        end
        return {y, z};
    endfunction

    task automatic report_mismatch(input string what, input tcbe_pkg::t_block got,
                                   input tcbe_pkg::t_block want);
        $display("[%0t] %s: cipher_block got %h want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic push_block(input logic first, input tcbe_pkg::t_block plain);
        tcbe_pkg::t_item it;
        it.plain = plain;
        it.first = first;
        plain_pending.push_back(it);
    endtask

    task automatic load_key(input tcbe_pkg::t_key k);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tcbe_pkg::KEY_W0;
        i_cfg_data <= k.k0;
        @(posedge i_clk);
        i_cfg_idx  <= tcbe_pkg::KEY_W1;
        i_cfg_data <= k.k1;
        @(posedge i_clk);
        i_cfg_idx  <= tcbe_pkg::KEY_W2;
        i_cfg_data <= k.k2;
        @(posedge i_clk);
        i_cfg_idx  <= tcbe_pkg::KEY_W3;
        i_cfg_data <= k.k3;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        key_model  <= k;
        key_loads++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        while (plain_pending.size() != 0 || cipher_expect.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // driver: hold the block until its transfer, then advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            tx_taken = s_axis_tvalid && s_axis_tready;
            if (tx_taken) begin
                mixed_v  = s_axis_tdata ^ (s_axis_tuser ? '0 : chain_cipher);
                cipher_v = tea_encipher(mixed_v, key_model)
                           ^ (s_axis_tuser ? '0 : chain_mixed);
                chain_mixed  = mixed_v;
                chain_cipher = cipher_v;
                cipher_expect.push_back(cipher_v);
                void'(plain_pending.pop_front());
                in_count    <= in_count + 1;
                first_count <= first_count + (s_axis_tuser ? 1 : 0);
            end
            if (!s_axis_tvalid || tx_taken) begin
                if (plain_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= plain_pending[0].plain;
                    s_axis_tuser  <= plain_pending[0].first;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the input side backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && in_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                out_count++;
                if (cipher_expect.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata, '0);
                end else begin
                    want_v = cipher_expect.pop_front();
                    if (m_axis_tdata !== want_v) begin
                        report_mismatch("wrong ciphertext", m_axis_tdata, want_v);
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, cipher_expect.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int               phase;
        int               n;
        int               len;
        int               r;
        int               j;
        tcbe_pkg::t_key   k;
        tcbe_pkg::t_block plain_v;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 16;
        rx_idle_pct = 70;
        load_key('0);

        // blocks ahead of any first-block mark use the reset chaining values
        push_block(1'b0, '0);
        push_block(1'b0, '1);
        push_block(1'b1, '0);
        push_block(1'b0, '0);
        push_block(1'b0, '1);
        push_block(1'b1, '1);
        push_block(1'b1, '1);
        push_block(1'b0, {32{2'b10}});
        push_block(1'b0, {32{2'b01}});
        push_block(1'b0, 64'h1);
        push_block(1'b0, {1'b1, 63'b0});
        push_block(1'b1, {32'h0, 32'hFFFFFFFF});
        push_block(1'b0, {32'hFFFFFFFF, 32'h0});
        drain();

        // key change in the middle of a message keeps the chain
        load_key('1);
        push_block(1'b0, 64'h0123456789ABCDEF);
        push_block(1'b0, '1);
        push_block(1'b1, '0);
        push_block(1'b0, {$urandom, $urandom});
        drain();

        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                1: k = '1;
                2: k = '{k0: '0, k1: '1, k2: '0, k3: '1};
                4: k = '{k0: '1, k1: '0, k2: '1, k3: '0};
                6: k = '0;
                default: begin
                    k.k0 = $urandom;
                    k.k1 = $urandom;
                    k.k2 = $urandom;
                    k.k3 = $urandom;
                end
            endcase
            if (phase < 3) begin
                tx_idle_pct = 16;
                rx_idle_pct = 70;
            end else if (phase < 6) begin
                tx_idle_pct = 70;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            load_key(k);
            n = 0;
            while (n < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    push_block(1'($urandom_range(1)), {$urandom, $urandom});
                    n++;
                end else begin
                    len = $urandom_range(1, 12);
                    for (j = 0; j < len; j++) begin
                        case ($urandom_range(19))
                            0: plain_v = '0;
                            1: plain_v = '1;
                            default: plain_v = {$urandom, $urandom};
                        endcase
                        push_block(j == 0 && r >= 12, plain_v);
                    end
                    n += len;
                end
            end
            drain();
        end

        repeat (3 * (ROUNDS + 1)) @(posedge i_clk);
        $display("%0d blocks (%0d marked first) under %0d keys, %0d ciphertexts checked",
                 in_count, first_count, key_loads, out_count);
        $display("sender/receiver idling in both orders, one long receiver hold-off");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
